[hdl/pht_pkg.sv]
// ---------------------------------------------------------------------------
// pht_pkg
// Types and constants shared by the position hypothesis tracker.
// ---------------------------------------------------------------------------
package pht_pkg;

   localparam logic [1:0] CSR_MATCH_RADIUS = 2'd0;
   localparam logic [1:0] CSR_DECAY_RATE   = 2'd1;
   localparam logic [1:0] CSR_PRUNE_THRESH = 2'd2;

   localparam logic [14:0]        RADIUS_RESET = 15'd333;
   localparam logic [15:0]        DECAY_RESET  = 16'd13520;
   localparam logic [15:0]        PRUNE_RESET  = 16'd1311;
   localparam logic signed [15:0] BEST_RESET   = -16'sd1638;
   localparam logic [16:0]        ONE_Q16      = 17'h10000;

   typedef struct packed {
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic [15:0]        c;
   } hyp_type;

   typedef enum logic [4:0] {
      ST_INIT, ST_IDLE, ST_R2A, ST_R2B,
      ST_M_RD, ST_M_DX, ST_M_DY, ST_M_CMP, ST_M_MUL, ST_M_WR, ST_M_FIN, ST_M_MRG,
      ST_W_RD, ST_W_CMP, ST_K_RD, ST_K_WR, ST_APPEND,
      ST_P_RD, ST_P_WR, ST_D_RD, ST_D_MUL, ST_D_WR, ST_EMIT
   } state_type;

endpackage

[hdl/position_hypothesis_tracker.sv]
// ---------------------------------------------------------------------------
// position_hypothesis_tracker
// Ball position tracker over a table of weighted hypotheses.
//
// Channels: req_* carries observations (kind 0) or an empty-frame marker
// (kind 1); rsp_* returns one estimate per finished frame; csr_* writes the
// match radius, decay rate and prune threshold, which the user must write
// only while the block is idle; the block itself does not enforce this.
// A non-final observation produces no transfer on rsp. A final observation
// walks the N table entries in a match pass and a prune pass, with a search
// for the weakest entry and a removal pass between them when the table is
// full and nothing matches; an empty frame walks them in one decay pass,
// paced by one shared 18x18 multiplier and the single table read port.
// req_ready is low while a frame is worked on. After reset the table holds
// one entry (0, 0, 1311), written in ST_INIT before req_ready rises.
// The result sits in an output register; a new item is taken while it waits.
// A stalled receiver holds the block only when a second result is ready.
// ---------------------------------------------------------------------------
module position_hypothesis_tracker #(
   parameter int MAX_HYPOTHESES = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_kind,
   input  logic signed [15:0] req_obs_x,
   input  logic signed [15:0] req_obs_y,
   input  logic signed [15:0] req_obs_certainty,
   input  logic        req_obs_last,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic signed [15:0] rsp_est_x,
   output logic signed [15:0] rsp_est_y,
   output logic [15:0] rsp_est_certainty,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);
   import pht_pkg::*;

   localparam int IDX_W = $clog2(MAX_HYPOTHESES);
   localparam int CNT_W = $clog2(MAX_HYPOTHESES + 1);
   localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_HYPOTHESES);

   state_type state_ff, state_in;

   hyp_type mem [MAX_HYPOTHESES];
   hyp_type rdata_ff;
   logic             rd_en, mem_we;
   logic [IDX_W-1:0] rd_addr, wr_addr;
   hyp_type          wr_data;

   logic signed [17:0] mul_a, mul_b;
   logic signed [35:0] prod_ff;

   logic [CNT_W-1:0] i_ff, i_in, w_ff, w_in, count_ff, count_in;
   logic [IDX_W-1:0] first_ff, first_in, weak_ff, weak_in;
   logic             found_ff, found_in, matched_ff, matched_in, any_ff, any_in;
   logic [16:0]      anti_ff, anti_in;
   logic [33:0]      acc_ff, acc_in;
   logic [29:0]      r2_ff, r2_in;
   logic [15:0]      minc_ff, minc_in, maxc_ff, maxc_in;
   logic signed [15:0] selx_ff, selx_in, sely_ff, sely_in;
   logic signed [15:0] px_ff, px_in, py_ff, py_in;
   logic signed [15:0] bx_ff, bx_in, by_ff, by_in, bc_ff, bc_in;
   logic signed [15:0] lx_ff, lx_in, ly_ff, ly_in;
   logic [14:0]      radius_ff;
   logic [15:0]      decay_ff, thresh_ff;
   logic             rv_ff, rv_in;
   logic signed [15:0] rx_ff, rx_in, ry_ff, ry_in;
   logic [15:0]      rc_ff, rc_in;

   logic               req_xfer, emit_go, pass_done, obs_better;
   logic signed [16:0] dx, dy;
   logic [16:0]        omd, omc, merge_a, merge_c;
   logic [15:0]        decayed, merge_cert;
   logic [33:0]        d2;

   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;
   assign req_xfer  = req_valid & req_ready;
   assign rsp_valid = rv_ff;
   assign rsp_est_x = rx_ff;
   assign rsp_est_y = ry_ff;
   assign rsp_est_certainty = rc_ff;

   assign pass_done  = (i_ff == count_ff);
   assign emit_go    = !rv_ff || rsp_ready;
   assign obs_better = req_obs_certainty > bc_ff;
   assign dx = {px_ff[15], px_ff} - {rdata_ff.x[15], rdata_ff.x};
   assign dy = {py_ff[15], py_ff} - {rdata_ff.y[15], rdata_ff.y};
   assign omd = ONE_Q16 - {1'b0, decay_ff};
   assign omc = ONE_Q16 - {1'b0, rdata_ff.c};
   assign decayed = prod_ff[31:16];
   assign merge_a = prod_ff[32:16];
   assign merge_c = ONE_Q16 - merge_a;
   assign merge_cert = merge_c[16] ? 16'hFFFF : merge_c[15:0];
   assign d2 = acc_ff + prod_ff[33:0];

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rdata_ff <= mem[rd_addr];
      end
      prod_ff <= mul_a * mul_b;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_INIT;
         i_ff      <= '0;
         w_ff      <= '0;
         count_ff  <= '0;
         found_ff  <= 1'b0;
         any_ff    <= 1'b0;
         rv_ff     <= 1'b0;
         bx_ff     <= '0;
         by_ff     <= '0;
         bc_ff     <= BEST_RESET;
         lx_ff     <= '0;
         ly_ff     <= '0;
         radius_ff <= RADIUS_RESET;
         decay_ff  <= DECAY_RESET;
         thresh_ff <= PRUNE_RESET;
      end else begin
         state_ff <= state_in;
         i_ff     <= i_in;
         w_ff     <= w_in;
         count_ff <= count_in;
         found_ff <= found_in;
         any_ff   <= any_in;
         rv_ff    <= rv_in;
         bx_ff    <= bx_in;
         by_ff    <= by_in;
         bc_ff    <= bc_in;
         lx_ff    <= lx_in;
         ly_ff    <= ly_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_MATCH_RADIUS: radius_ff <= csr_data[14:0];
               CSR_DECAY_RATE:   decay_ff  <= csr_data;
               CSR_PRUNE_THRESH: thresh_ff <= csr_data;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      first_ff   <= first_in;
      weak_ff    <= weak_in;
      matched_ff <= matched_in;
      anti_ff    <= anti_in;
      acc_ff     <= acc_in;
      r2_ff      <= r2_in;
      minc_ff    <= minc_in;
      maxc_ff    <= maxc_in;
      selx_ff    <= selx_in;
      sely_ff    <= sely_in;
      px_ff      <= px_in;
      py_ff      <= py_in;
      rx_ff      <= rx_in;
      ry_ff      <= ry_in;
      rc_ff      <= rc_in;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_INIT: state_in = ST_IDLE;
         ST_IDLE: begin
            if (req_xfer) begin
               if (req_kind) state_in = ST_D_RD;
               else if (req_obs_last) state_in = ST_R2A;
            end
         end
         ST_R2A:   state_in = ST_R2B;
         ST_R2B:   state_in = ST_M_RD;
         ST_M_RD:  state_in = pass_done ? ST_M_FIN : ST_M_DX;
         ST_M_DX:  state_in = ST_M_DY;
         ST_M_DY:  state_in = ST_M_CMP;
         ST_M_CMP: state_in = ST_M_MUL;
         ST_M_MUL: state_in = ST_M_WR;
         ST_M_WR:  state_in = ST_M_RD;
         ST_M_FIN: begin
            if (found_ff) state_in = ST_M_MRG;
            else if (w_ff >= MAX_CNT) state_in = ST_W_RD;
            else state_in = ST_APPEND;
         end
         ST_M_MRG:  state_in = ST_P_RD;
         ST_W_RD:   state_in = pass_done ? ST_K_RD : ST_W_CMP;
         ST_W_CMP:  state_in = ST_W_RD;
         ST_K_RD:   state_in = pass_done ? ST_APPEND : ST_K_WR;
         ST_K_WR:   state_in = ST_K_RD;
         ST_APPEND: state_in = ST_P_RD;
         ST_P_RD:   state_in = pass_done ? ST_EMIT : ST_P_WR;
         ST_P_WR:   state_in = ST_P_RD;
         ST_D_RD:   state_in = pass_done ? ST_EMIT : ST_D_MUL;
         ST_D_MUL:  state_in = ST_D_WR;
         ST_D_WR:   state_in = ST_D_RD;
         ST_EMIT:   state_in = emit_go ? ST_IDLE : ST_EMIT;
         default:   state_in = ST_INIT;
      endcase
   end

   always_comb begin
      rd_en = 1'b0;
      rd_addr = i_ff[IDX_W-1:0];
      mem_we = 1'b0;
      wr_addr = w_ff[IDX_W-1:0];
      wr_data = rdata_ff;
      mul_a = '0;
      mul_b = '0;
      i_in = i_ff;
      w_in = w_ff;
      count_in = count_ff;
      first_in = first_ff;
      weak_in = weak_ff;
      found_in = found_ff;
      matched_in = matched_ff;
      any_in = any_ff;
      anti_in = anti_ff;
      acc_in = acc_ff;
      r2_in = r2_ff;
      minc_in = minc_ff;
      maxc_in = maxc_ff;
      selx_in = selx_ff;
      sely_in = sely_ff;
      px_in = px_ff;
      py_in = py_ff;
      bx_in = bx_ff;
      by_in = by_ff;
      bc_in = bc_ff;
      lx_in = lx_ff;
      ly_in = ly_ff;
      rx_in = rx_ff;
      ry_in = ry_ff;
      rc_in = rc_ff;
      rv_in = rv_ff && !rsp_ready;

      unique case (state_ff)
         ST_INIT: begin
            mem_we = 1'b1;
            wr_addr = '0;
            wr_data = '{x: '0, y: '0, c: PRUNE_RESET};
            count_in = CNT_W'(1);
         end
         ST_IDLE: begin
            i_in = '0;
            w_in = '0;
            any_in = 1'b0;
            maxc_in = '0;
            if (req_xfer) begin
               if (req_kind) begin
                  bx_in = '0;
                  by_in = '0;
                  bc_in = BEST_RESET;
               end else begin
                  if (obs_better) begin
                     bx_in = req_obs_x;
                     by_in = req_obs_y;
                     bc_in = req_obs_certainty;
                  end
                  px_in = obs_better ? req_obs_x : bx_ff;
                  py_in = obs_better ? req_obs_y : by_ff;
               end
            end
         end
         ST_R2A: begin
            mul_a = {3'b0, radius_ff};
            mul_b = {3'b0, radius_ff};
         end
         ST_R2B: begin
            r2_in = prod_ff[29:0];
            found_in = 1'b0;
            anti_in = ONE_Q16;
         end
         ST_M_RD: rd_en = !pass_done;
         ST_M_DX: begin
            mul_a = {dx[16], dx};
            mul_b = {dx[16], dx};
         end
         ST_M_DY: begin
            mul_a = {dy[16], dy};
            mul_b = {dy[16], dy};
            acc_in = prod_ff[33:0];
         end
         ST_M_CMP: matched_in = d2 < {4'b0, r2_ff};
         ST_M_MUL: begin
            if (matched_ff) begin
               mul_a = {1'b0, anti_ff};
               mul_b = {1'b0, omc};
            end else begin
               mul_a = {2'b0, rdata_ff.c};
               mul_b = {1'b0, omd};
            end
         end
         ST_M_WR: begin
            i_in = i_ff + 1'b1;
            if (matched_ff) begin
               anti_in = merge_a;
               if (!found_ff) begin
                  found_in = 1'b1;
                  first_in = w_ff[IDX_W-1:0];
                  w_in = w_ff + 1'b1;
               end
            end else begin
               mem_we = 1'b1;
               wr_data.c = decayed;
               w_in = w_ff + 1'b1;
            end
         end
         ST_M_FIN: begin
            count_in = w_ff;
            i_in = '0;
            w_in = '0;
            mul_a = {1'b0, anti_ff};
            mul_b = {1'b0, omd};
            if (!found_ff && bc_ff < 0) begin
               px_in = lx_ff;
               py_in = ly_ff;
            end
         end
         ST_M_MRG: begin
            mem_we = 1'b1;
            wr_addr = first_ff;
            wr_data = '{x: px_ff, y: py_ff, c: merge_cert};
         end
         ST_W_RD: begin
            rd_en = !pass_done;
            if (pass_done) begin
               i_in = '0;
               w_in = '0;
            end
         end
         ST_W_CMP: begin
            i_in = i_ff + 1'b1;
            if (i_ff == '0 || rdata_ff.c < minc_ff) begin
               minc_in = rdata_ff.c;
               weak_in = i_ff[IDX_W-1:0];
            end
         end
         ST_K_RD: begin
            rd_en = !pass_done;
            if (pass_done) count_in = w_ff;
         end
         ST_K_WR: begin
            i_in = i_ff + 1'b1;
            if (i_ff[IDX_W-1:0] != weak_ff) begin
               mem_we = 1'b1;
               w_in = w_ff + 1'b1;
            end
         end
         ST_APPEND: begin
            mem_we = 1'b1;
            wr_addr = count_ff[IDX_W-1:0];
            wr_data = '{x: px_ff, y: py_ff, c: decay_ff};
            count_in = count_ff + 1'b1;
            i_in = '0;
            w_in = '0;
         end
         ST_P_RD: begin
            rd_en = !pass_done;
            if (pass_done) count_in = w_ff;
         end
         ST_P_WR: begin
            i_in = i_ff + 1'b1;
            if (rdata_ff.c >= thresh_ff) begin
               mem_we = 1'b1;
               w_in = w_ff + 1'b1;
               if (!any_ff || maxc_ff < rdata_ff.c) begin
                  any_in = 1'b1;
                  maxc_in = rdata_ff.c;
                  selx_in = rdata_ff.x;
                  sely_in = rdata_ff.y;
               end
            end
         end
         ST_D_RD: rd_en = !pass_done;
         ST_D_MUL: begin
            mul_a = {2'b0, rdata_ff.c};
            mul_b = {1'b0, omd};
         end
         ST_D_WR: begin
            mem_we = 1'b1;
            wr_addr = i_ff[IDX_W-1:0];
            wr_data.c = decayed;
            i_in = i_ff + 1'b1;
            if (!any_ff || maxc_ff < decayed) begin
               any_in = 1'b1;
               maxc_in = decayed;
               selx_in = rdata_ff.x;
               sely_in = rdata_ff.y;
            end
         end
         ST_EMIT: begin
            if (emit_go) begin
               rv_in = 1'b1;
               bx_in = '0;
               by_in = '0;
               bc_in = BEST_RESET;
               if (count_ff == '0) begin
                  rx_in = lx_ff;
                  ry_in = ly_ff;
                  rc_in = '0;
               end else begin
                  rx_in = selx_ff;
                  ry_in = sely_ff;
                  rc_in = maxc_ff;
                  lx_in = selx_ff;
                  ly_in = sely_ff;
               end
            end
         end
         default: ;
      endcase
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= MAX_CNT) else $error("hypothesis count above table depth");

   a_compact_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_M_WR || state_ff == ST_K_WR || state_ff == ST_P_WR)
      |-> w_ff <= i_ff) else $error("compaction write passes read pointer");

   a_empty_frame: assert property (@(posedge clock) disable iff (reset)
      (req_xfer && req_kind) |=> state_ff == ST_D_RD)
      else $error("empty frame did not start decay pass");

endmodule

[verif/position_hypothesis_tracker_tb.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// position_hypothesis_tracker_tb
// Self-checking bench for the position hypothesis tracker. Observations and
// empty-frame markers are queued by a stimulus process and sent by a driver
// with random gaps. Each accepted transfer updates a local tracker model that
// queues the expected estimate. A monitor with random back-pressure checks
// every estimate against that queue. The bench steps through several
// settings of radius, decay and prune threshold, extremes included.
// ---------------------------------------------------------------------------
module position_hypothesis_tracker_tb;
   import pht_pkg::*;

   localparam int  DEPTH     = 64;
   localparam int  N_ITEMS   = 1650;
   localparam longint LIMIT  = 10000000;

   typedef struct {
      logic               kind;
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic signed [15:0] c;
      logic               last;
   } obs_type;

   typedef struct {
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic [15:0]        c;
   } est_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic req_kind = 1'b0;
   logic signed [15:0] req_obs_x = '0;
   logic signed [15:0] req_obs_y = '0;
   logic signed [15:0] req_obs_certainty = '0;
   logic req_obs_last = 1'b0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [15:0] rsp_est_x;
   logic signed [15:0] rsp_est_y;
   logic [15:0] rsp_est_certainty;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [1:0] csr_index = CSR_MATCH_RADIUS;
   logic [15:0] csr_data = '0;

   position_hypothesis_tracker #(.MAX_HYPOTHESES(DEPTH)) dut (.*);

   // tracker model state
   int unsigned radius_mm, decay_q16, prune_q16;
   int hyp_x [DEPTH];
   int hyp_y [DEPTH];
   longint unsigned hyp_c [DEPTH];
   int hyp_n;
   int last_x, last_y;
   int best_x, best_y, best_c;

   obs_type pending_obs[$];
   est_type est_q[$];
   obs_type cur_obs;
   int gap_left = 0;
   int burst_left = 0;
   bit calm = 0;
   bit hold_req = 0;
   bit hold_seen = 0;
   int hold_left = 0;
   int mismatches = 0;
   int frames_seen = 0;
   int items_sent = 0;
   longint cycles = 0;

   function automatic longint unsigned decayed(longint unsigned c);
      return (c * (65536 - decay_q16)) >> 16;
   endfunction

   task automatic report_estimate();
      est_type e;
      int sel;
      longint unsigned maxc;
      sel = 0;
      maxc = 0;
      if (hyp_n <= 0) begin
         e.x = last_x[15:0];
         e.y = last_y[15:0];
         e.c = '0;
      end else begin
         for (int i = 0; i < hyp_n; i++)
            if (maxc < hyp_c[i]) begin
               maxc = hyp_c[i];
               sel = i;
            end
         last_x = hyp_x[sel];
         last_y = hyp_y[sel];
         e.x = last_x[15:0];
         e.y = last_y[15:0];
         e.c = hyp_c[sel][15:0];
      end
      best_x = 0;
      best_y = 0;
      best_c = int'(BEST_RESET);
      est_q = {est_q, e};
   endtask

   task automatic close_frame();
      int px, py, first, w, weakest;
      longint unsigned anti, c, r2, d2;
      longint dx, dy;
      bit hit [DEPTH];
      px = best_x;
      py = best_y;
      r2 = longint'(radius_mm) * radius_mm;
      anti = 65536;
      first = -1;
      for (int i = 0; i < hyp_n; i++) begin
         dx = longint'(px) - hyp_x[i];
         dy = longint'(py) - hyp_y[i];
         d2 = dx * dx + dy * dy;
         hit[i] = d2 < r2;
         if (hit[i]) begin
            if (first < 0) first = i;
            anti = (anti * (65536 - hyp_c[i])) >> 16;
         end else
            hyp_c[i] = decayed(hyp_c[i]);
      end
      if (first >= 0) begin
         anti = (anti * (65536 - decay_q16)) >> 16;
         c = 65536 - anti;
         if (c > 65535) c = 65535;
         hyp_x[first] = px;
         hyp_y[first] = py;
         hyp_c[first] = c;
         w = 0;
         for (int i = 0; i < hyp_n; i++)
            if (i == first || !hit[i]) begin
               hyp_x[w] = hyp_x[i];
               hyp_y[w] = hyp_y[i];
               hyp_c[w] = hyp_c[i];
               w++;
            end
         hyp_n = w;
      end else begin
         if (best_c < 0) begin
            px = last_x;
            py = last_y;
         end
         if (hyp_n >= DEPTH) begin
            weakest = 0;
            for (int i = 1; i < hyp_n; i++)
               if (hyp_c[i] < hyp_c[weakest]) weakest = i;
            for (int i = weakest; i + 1 < hyp_n; i++) begin
               hyp_x[i] = hyp_x[i + 1];
               hyp_y[i] = hyp_y[i + 1];
               hyp_c[i] = hyp_c[i + 1];
            end
            hyp_n--;
         end
         hyp_x[hyp_n] = px;
         hyp_y[hyp_n] = py;
         hyp_c[hyp_n] = decay_q16;
         hyp_n++;
      end
      w = 0;
      for (int i = 0; i < hyp_n; i++)
         if (hyp_c[i] >= prune_q16) begin
            hyp_x[w] = hyp_x[i];
            hyp_y[w] = hyp_y[i];
            hyp_c[w] = hyp_c[i];
            w++;
         end
      hyp_n = w;
   endtask

   task automatic track_obs(obs_type o);
      if (o.kind) begin
         for (int i = 0; i < hyp_n; i++) hyp_c[i] = decayed(hyp_c[i]);
         report_estimate();
         return;
      end
      if (best_c < int'(o.c)) begin
         best_x = int'(o.x);
         best_y = int'(o.y);
         best_c = int'(o.c);
      end
      if (!o.last) return;
      close_frame();
      report_estimate();
   endtask

   task automatic queue_obs(bit kind, int x, int y, int c, bit last);
      obs_type o;
      o.kind = kind;
      o.x = x[15:0];
      o.y = y[15:0];
      o.c = c[15:0];
      o.last = last;
      pending_obs = {pending_obs, o};
   endtask

   task automatic write_reg(logic [1:0] idx, int unsigned val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val[15:0];
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_MATCH_RADIUS: radius_mm = val & 32'h7fff;
         CSR_DECAY_RATE:   decay_q16 = val & 32'hffff;
         CSR_PRUNE_THRESH: prune_q16 = val & 32'hffff;
         default: ;
      endcase
   endtask

   task automatic drain();
      do @(negedge clock);
      while (pending_obs.size() != 0 || req_valid || est_q.size() != 0);
      repeat (50) @(posedge clock);
   endtask

   function automatic int clip16(int v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
   endfunction

   task automatic random_frames(int count, int spread);
      int sent, sel, n, cx, cy;
      sent = 0;
      cx = $urandom_range(0, 4000) - 2000;
      cy = $urandom_range(0, 4000) - 2000;
      while (sent < count) begin
         sel = $urandom_range(0, 99);
         if (sel < 8) begin
            queue_obs(1, $urandom, $urandom, $urandom, 1'($urandom));
            sent++;
         end else if (sel < 14) begin
            n = $urandom_range(1, 3);
            for (int i = 0; i < n; i++)
               queue_obs(0, cx, cy, $urandom_range(0, 20000), 0);
            queue_obs(1, $urandom, $urandom, $urandom, 1'($urandom));
            sent += n + 1;
         end else if (sel < 22) begin
            n = $urandom_range(1, 3);
            for (int i = 0; i < n; i++)
               queue_obs(0, $urandom, $urandom, $urandom, i == n - 1);
            sent += n;
         end else begin
            if ($urandom_range(0, 9) == 0) begin
               cx = $urandom_range(0, 60000) - 30000;
               cy = $urandom_range(0, 60000) - 30000;
            end else begin
               cx = clip16(cx + $urandom_range(0, 2 * spread) - spread);
               cy = clip16(cy + $urandom_range(0, 2 * spread) - spread);
            end
            n = $urandom_range(1, 4);
            for (int i = 0; i < n; i++)
               queue_obs(0, clip16(cx + $urandom_range(0, 2 * spread) - spread),
                         clip16(cy + $urandom_range(0, 2 * spread) - spread),
                         $urandom_range(0, 18000) - 1700, i == n - 1);
            sent += n;
         end
      end
      items_sent += sent;
   endtask

   initial begin
      forever #5 clock = ~clock;
   end

   // driver
   always @(posedge clock) begin : drive_req
      logic nv;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         nv = req_valid;
         if (req_valid && req_ready) begin
            track_obs(cur_obs);
            nv = 1'b0;
         end
         if (!nv) begin
            if (gap_left > 0)
               gap_left--;
            else if (pending_obs.size() != 0) begin
               cur_obs = pending_obs.pop_front();
               nv = 1'b1;
               req_kind <= cur_obs.kind;
               req_obs_x <= cur_obs.x;
               req_obs_y <= cur_obs.y;
               req_obs_certainty <= cur_obs.c;
               req_obs_last <= cur_obs.last;
               if (!calm && $urandom_range(0, 5) == 0) gap_left = $urandom_range(1, 16);
            end
         end
         req_valid <= nv;
      end
   end

   // receiver back-pressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_req != hold_seen) begin
         hold_seen = hold_req;
         hold_left = 4000;
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (calm) begin
         rsp_ready <= 1'b1;
      end else if (burst_left > 0) begin
         burst_left--;
         rsp_ready <= 1'b0;
      end else if ($urandom_range(0, 7) == 0) begin
         burst_left = $urandom_range(0, 15);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // monitor
   always @(posedge clock) begin : check_rsp
      est_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         frames_seen++;
         if (est_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected estimate x=%0d y=%0d c=%0d",
                        rsp_est_x, rsp_est_y, rsp_est_certainty);
         end else begin
            e = est_q.pop_front();
            if (rsp_est_x !== e.x || rsp_est_y !== e.y || rsp_est_certainty !== e.c) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("estimate %0d: expected (%0d,%0d,%0d) got (%0d,%0d,%0d)",
                           frames_seen, e.x, e.y, e.c,
                           rsp_est_x, rsp_est_y, rsp_est_certainty);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("position_hypothesis_tracker: mismatch");
         $finish;
      end
   end

   initial begin
      radius_mm = RADIUS_RESET;
      decay_q16 = DECAY_RESET;
      prune_q16 = PRUNE_RESET;
      for (int i = 0; i < DEPTH; i++) begin
         hyp_x[i] = 0;
         hyp_y[i] = 0;
         hyp_c[i] = 0;
      end
      hyp_c[0] = PRUNE_RESET;
      hyp_n = 1;
      last_x = 0;
      last_y = 0;
      best_x = 0;
      best_y = 0;
      best_c = int'(BEST_RESET);
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed frames at reset settings
      queue_obs(0, 0, 0, 16384, 1);
      queue_obs(0, 32767, 32767, 32767, 0);
      queue_obs(0, -32768, -32768, -32768, 1);
      queue_obs(0, 100, 100, -1638, 1);
      queue_obs(0, 200, -200, -1637, 1);
      queue_obs(0, 5, 5, -2000, 0);
      queue_obs(1, -1, -1, -1, 1);
      queue_obs(0, 10, 10, 500, 0);
      queue_obs(0, 900, 900, 500, 1);
      queue_obs(0, 32767, -32768, 0, 1);
      queue_obs(1, 0, 0, 0, 0);
      queue_obs(1, 0, 0, 0, 0);
      queue_obs(0, 0, 0, 16384, 1);
      queue_obs(0, 50, 50, 8000, 1);
      queue_obs(1, 0, 0, 0, 1);
      items_sent += 15;
      drain();

      // table fills: nothing matches, nothing pruned
      write_reg(CSR_MATCH_RADIUS, 0);
      write_reg(CSR_PRUNE_THRESH, 0);
      write_reg(CSR_DECAY_RATE, 3000);
      random_frames(300, 3000);
      drain();

      // maximum settings, receiver held off while sender keeps offering
      write_reg(CSR_MATCH_RADIUS, 32767);
      write_reg(CSR_DECAY_RATE, 65535);
      write_reg(CSR_PRUNE_THRESH, 65535);
      hold_req = 1;
      random_frames(250, 500);
      drain();

      write_reg(CSR_MATCH_RADIUS, 50);
      write_reg(CSR_DECAY_RATE, 0);
      write_reg(CSR_PRUNE_THRESH, 0);
      random_frames(250, 80);
      drain();

      write_reg(CSR_MATCH_RADIUS, 2000);
      write_reg(CSR_DECAY_RATE, 40000);
      write_reg(CSR_PRUNE_THRESH, 500);
      random_frames(300, 2500);
      drain();

      write_reg(CSR_MATCH_RADIUS, 333);
      write_reg(CSR_DECAY_RATE, 13520);
      write_reg(CSR_PRUNE_THRESH, 1311);
      random_frames(300, 400);
      drain();

      calm = 1;
      random_frames(250, 400);
      drain();
      repeat (1000) @(posedge clock);

      $display("sent %0d items under six settings, checked %0d estimates",
               items_sent, frames_seen);
      if (mismatches == 0 && est_q.size() == 0)
         $display("position_hypothesis_tracker: match");
      else begin
         $display("%0d mismatches, %0d estimates missing", mismatches, est_q.size());
         $display("position_hypothesis_tracker: mismatch");
      end
      $finish;
   end

endmodule

[sim.f]
hdl/pht_pkg.sv
hdl/position_hypothesis_tracker.sv
verif/position_hypothesis_tracker_tb.sv
